>>> sv/lbm_pkg.sv
// lbm_pkg: types, constants and helper functions for the D2Q9 BGK collision pipeline.
`timescale 1ns / 1ps
package lbm_pkg;

    localparam int WORD_W        = 32;
    localparam int NDIR          = 9;
    localparam int FRAC_BITS_DEF = 16;
    localparam int RATE_FRAC     = 16;
    localparam int RELAX_W       = 18;
    localparam logic [RELAX_W-1:0] RELAX_RESET = 18'd109227;

    localparam logic signed [63:0] SAT_MAX_64 = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN_64 = -64'sd2147483648;

    // direction codes, velocities (0,0) (0,1) (1,1) (1,0) (1,-1) (0,-1) (-1,-1) (-1,0) (-1,1)
    localparam logic [3:0] DIR_REST = 4'd0;
    localparam logic [3:0] DIR_N    = 4'd1;
    localparam logic [3:0] DIR_NE   = 4'd2;
    localparam logic [3:0] DIR_E    = 4'd3;
    localparam logic [3:0] DIR_SE   = 4'd4;
    localparam logic [3:0] DIR_S    = 4'd5;
    localparam logic [3:0] DIR_SW   = 4'd6;
    localparam logic [3:0] DIR_W    = 4'd7;
    localparam logic [3:0] DIR_NW   = 4'd8;

    // weight classes
    localparam logic [1:0] WCLS_REST = 2'd0;
    localparam logic [1:0] WCLS_AXIS = 2'd1;
    localparam logic [1:0] WCLS_DIAG = 2'd2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [NDIR-1:0][WORD_W-1:0] t_dirs;

    typedef struct packed {
        logic  obstacle;
        t_word dist_rest;
        t_word dist_n;
        t_word dist_ne;
        t_word dist_e;
        t_word dist_se;
        t_word dist_s;
        t_word dist_sw;
        t_word dist_w;
        t_word dist_nw;
    } t_cell_in;

    typedef struct packed {
        t_word out_rest;
        t_word out_n;
        t_word out_ne;
        t_word out_e;
        t_word out_se;
        t_word out_s;
        t_word out_sw;
        t_word out_w;
        t_word out_nw;
        t_word cell_density;
    } t_cell_out;

    // data that rides along the whole pipe
    typedef struct packed {
        logic  obstacle;
        t_word rho;
        t_dirs f;
    } t_side;

    // one lane of the restoring divider
    typedef struct packed {
        logic [30:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } t_lane;

    function automatic t_word sat32(input logic signed [63:0] v);
        if (v > SAT_MAX_64) begin
            return SAT_MAX_64[31:0];
        end else if (v < SAT_MIN_64) begin
            return SAT_MIN_64[31:0];
        end else begin
            return v[31:0];
        end
    endfunction

    // shift right with round to nearest, ties away from zero
    function automatic logic signed [63:0] qm_round(input logic signed [63:0] p,
                                                    input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] r;
        mag = p[63] ? 64'(-p) : 64'(p);
        r   = (mag + (64'd1 << (sh - 1))) >> sh;
        return p[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic t_lane div_step(input t_lane l, input logic [30:0] d);
        t_lane       o;
        logic [31:0] rem2;
        logic        qb;
        rem2 = {l.rem, l.low[31]};
        qb   = (rem2 >= {1'b0, d});
        o      = l;
        o.rem  = qb ? 31'(rem2 - {1'b0, d}) : rem2[30:0];
        o.low  = {l.low[30:0], 1'b0};
        o.quo  = {l.quo[30:0], qb};
        return o;
    endfunction

    function automatic t_word quot_sat(input t_lane l);
        if (l.ovf) begin
            return l.neg ? SAT_MIN_64[31:0] : SAT_MAX_64[31:0];
        end else if (l.neg) begin
            return (l.quo > 32'h8000_0000) ? SAT_MIN_64[31:0] : 32'(-l.quo);
        end else begin
            return l.quo[31] ? SAT_MAX_64[31:0] : l.quo;
        end
    endfunction

    function automatic t_word cu_of(input logic [3:0] dir, input t_word ux, input t_word uy);
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] s;
        x = 34'(ux);
        y = 34'(uy);
        unique case (dir)
            DIR_REST: s = '0;
            DIR_N:    s = y;
            DIR_NE:   s = x + y;
            DIR_E:    s = x;
            DIR_SE:   s = x - y;
            DIR_S:    s = -y;
            DIR_SW:   s = -x - y;
            DIR_W:    s = -x;
            DIR_NW:   s = y - x;
            default:  s = '0;
        endcase
        return sat32(64'(s));
    endfunction

    function automatic logic [3:0] opp_of(input logic [3:0] dir);
        logic [3:0] o;
        unique case (dir)
            DIR_REST: o = DIR_REST;
            DIR_N:    o = DIR_S;
            DIR_NE:   o = DIR_SW;
            DIR_E:    o = DIR_W;
            DIR_SE:   o = DIR_NW;
            DIR_S:    o = DIR_N;
            DIR_SW:   o = DIR_NE;
            DIR_W:    o = DIR_E;
            DIR_NW:   o = DIR_SE;
            default:  o = DIR_REST;
        endcase
        return o;
    endfunction

    function automatic logic [1:0] wcls_of(input logic [3:0] dir);
        logic [1:0] c;
        unique case (dir)
            DIR_REST:                     c = WCLS_REST;
            DIR_N, DIR_E, DIR_S, DIR_W:   c = WCLS_AXIS;
            DIR_NE, DIR_SE, DIR_SW, DIR_NW: c = WCLS_DIAG;
            default:                      c = WCLS_REST;
        endcase
        return c;
    endfunction

endpackage

>>> sv/lbm_d2q9_cell_collision.sv
// lbm_d2q9_cell_collision: pipelined D2Q9 BGK collision / bounce-back for one cell per cycle while results are taken.
//
//   channel   | signals                       | moves
//   ----------+-------------------------------+-------------------------------------
//   cell in   | i_in_valid o_in_ready i_cell  | obstacle flag + nine distributions
//   result    | o_out_valid i_out_ready       | nine new distributions + density
//             | o_result                      |
//   config    | i_cfg_we i_cfg_data           | relax_rate (omega, unsigned Q2.16)
//
// One transaction per cycle sustained while the result side is ready; 48 register stages,
// most of them in the 32-stage restoring divider that forms the two velocity components
// (one quotient bit per stage).
// Synchronous active-low reset clears the stage valid bits and loads relax_rate.
// Each stage holds while its successor is full and stalled, so bubbles close up and
// input keeps being taken while a result waits, until the pipe is full.
`timescale 1ns / 1ps
module lbm_d2q9_cell_collision
    import lbm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_cell_in           i_cell,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_cell_out          o_result,
    input  logic               i_cfg_we,
    input  logic [RELAX_W-1:0] i_cfg_data
);

    // ---------------- stage map ----------------
    // S0 input reg, S1 triple sums, S2 density/moments, S3 saturate + magnitudes,
    // S4 divider setup, 32 quotient stages, E1..E11 velocity to relaxed result.
    localparam int DIV_N = 32;
    localparam int S0    = 0;
    localparam int S1    = 1;
    localparam int S2    = 2;
    localparam int S3    = 3;
    localparam int S4    = 4;
    localparam int E1    = S4 + DIV_N + 1;
    localparam int E2    = E1 + 1;
    localparam int E3    = E1 + 2;
    localparam int E4    = E1 + 3;
    localparam int E5    = E1 + 4;
    localparam int E6    = E1 + 5;
    localparam int E7    = E1 + 6;
    localparam int E8    = E1 + 7;
    localparam int E9    = E1 + 8;
    localparam int E10   = E1 + 9;
    localparam int E11   = E1 + 10;
    localparam int LAST  = E11;
    localparam int NSTG  = LAST + 1;

    localparam int F      = FRAC_BITS;
    localparam int SH     = 32 - F;          // numerator bits below the first quotient bit
    localparam int CMP_W  = 31 + SH;         // width of the overflow compare
    localparam int PRW_W  = WORD_W + F + 2;  // rho * weight
    localparam int SQ_W   = 63 - F;          // rounded cu^2 magnitude
    localparam int PS_W   = SQ_W + 6;        // polynomial accumulator
    localparam int DP_W   = RELAX_W + WORD_W + 1;

    // weights rounded to F fraction bits
    localparam int ONE_I  = 1 << F;
    localparam logic signed [F+1:0] W_REST = (F+2)'((8 * ONE_I + 9) / 18);
    localparam logic signed [F+1:0] W_AXIS = (F+2)'((2 * ONE_I + 9) / 18);
    localparam logic signed [F+1:0] W_DIAG = (F+2)'((2 * ONE_I + 36) / 72);

    // ---------------- config ----------------
    logic [RELAX_W-1:0] r_relax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax <= RELAX_RESET;
        end else if (i_cfg_we) begin
            r_relax <= i_cfg_data;
        end
    end

    // ---------------- flow control ----------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] stg_en;

    assign stg_en[LAST] = !r_vld[LAST] || i_out_ready;
    for (genvar s = 0; s < LAST; s++) begin : g_en
        assign stg_en[s] = !r_vld[s] || stg_en[s+1];
    end

    always_comb begin
        n_vld[0] = i_in_valid;
        for (int s = 1; s < NSTG; s++) begin
            n_vld[s] = r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NSTG; s++) begin
                if (stg_en[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    assign o_in_ready  = stg_en[S0];
    assign o_out_valid = r_vld[LAST];

    // ---------------- sideband: obstacle, density, inputs ----------------
    t_side r_side [S0:LAST];
    t_word sat_rho;

    always_ff @(posedge i_clk) begin
        if (stg_en[S0]) begin
            r_side[S0].obstacle <= i_cell.obstacle;
            r_side[S0].rho      <= '0;
            r_side[S0].f        <= {i_cell.dist_nw, i_cell.dist_w, i_cell.dist_sw,
                                    i_cell.dist_s, i_cell.dist_se, i_cell.dist_e,
                                    i_cell.dist_ne, i_cell.dist_n, i_cell.dist_rest};
        end
    end

    for (genvar s = S1; s <= LAST; s++) begin : g_side
        if (s == S3) begin : g_rho
            // density is saturated once here and carried from then on
            always_ff @(posedge i_clk) begin
                if (stg_en[s]) begin
                    r_side[s].obstacle <= r_side[s-1].obstacle;
                    r_side[s].rho      <= sat_rho;
                    r_side[s].f        <= r_side[s-1].f;
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (stg_en[s]) begin
                    r_side[s] <= r_side[s-1];
                end
            end
        end
    end

    // ---------------- S1: partial sums of three ----------------
    logic signed [33:0] r_s1_pc, r_s1_pe, r_s1_pw, r_s1_pn, r_s1_ps;

    function automatic logic signed [33:0] fx(input t_dirs f, input logic [3:0] dir);
        return 34'($signed(f[dir]));
    endfunction

    always_ff @(posedge i_clk) begin
        if (stg_en[S1]) begin
            r_s1_pc <= fx(r_side[S0].f, DIR_REST) + fx(r_side[S0].f, DIR_N)
                       + fx(r_side[S0].f, DIR_S);
            r_s1_pe <= fx(r_side[S0].f, DIR_NE) + fx(r_side[S0].f, DIR_E)
                       + fx(r_side[S0].f, DIR_SE);
            r_s1_pw <= fx(r_side[S0].f, DIR_SW) + fx(r_side[S0].f, DIR_W)
                       + fx(r_side[S0].f, DIR_NW);
            r_s1_pn <= fx(r_side[S0].f, DIR_N) + fx(r_side[S0].f, DIR_NE)
                       + fx(r_side[S0].f, DIR_NW);
            r_s1_ps <= fx(r_side[S0].f, DIR_SE) + fx(r_side[S0].f, DIR_S)
                       + fx(r_side[S0].f, DIR_SW);
        end
    end

    // ---------------- S2: exact density and first moments ----------------
    logic signed [35:0] r_s2_sum;
    logic signed [34:0] r_s2_mx, r_s2_my;

    always_ff @(posedge i_clk) begin
        if (stg_en[S2]) begin
            r_s2_sum <= 36'(r_s1_pc) + 36'(r_s1_pe) + 36'(r_s1_pw);
            r_s2_mx  <= 35'(r_s1_pe) - 35'(r_s1_pw);
            r_s2_my  <= 35'(r_s1_pn) - 35'(r_s1_ps);
        end
    end

    // ---------------- S3: saturate density, moment magnitudes ----------------
    logic [33:0] r_s3_magx, r_s3_magy;
    logic        r_s3_negx, r_s3_negy;

    assign sat_rho = sat32(64'(r_s2_sum));

    always_ff @(posedge i_clk) begin
        if (stg_en[S3]) begin
            r_s3_magx <= r_s2_mx[34] ? 34'(-r_s2_mx) : 34'(r_s2_mx);
            r_s3_magy <= r_s2_my[34] ? 34'(-r_s2_my) : 34'(r_s2_my);
            r_s3_negx <= r_s2_mx[34];
            r_s3_negy <= r_s2_my[34];
        end
    end

    // ---------------- S4 + quotient stages: u = m * 2^F / rho ----------------
    // Quotients of 2^32 or more are caught up front; the remaining 32 bits come
    // one per stage. A non-positive density uses divisor 1 (result is bypassed).
    t_lane       r_lx [S4:S4+DIV_N];
    t_lane       r_ly [S4:S4+DIV_N];
    logic [30:0] r_dv [S4:S4+DIV_N];
    logic [30:0] s4_d;

    assign s4_d = ($signed(r_side[S3].rho) > 0) ? r_side[S3].rho[30:0] : 31'd1;

    function automatic t_lane lane_init(input logic [33:0] mag, input logic neg,
                                        input logic [30:0] d);
        t_lane l;
        l.ovf = CMP_W'(mag) >= {d, {SH{1'b0}}};
        l.rem = 31'(mag >> SH);
        l.low = {mag[SH-1:0], {F{1'b0}}};
        l.quo = '0;
        l.neg = neg;
        return l;
    endfunction

    always_ff @(posedge i_clk) begin
        if (stg_en[S4]) begin
            r_lx[S4] <= lane_init(r_s3_magx, r_s3_negx, s4_d);
            r_ly[S4] <= lane_init(r_s3_magy, r_s3_negy, s4_d);
            r_dv[S4] <= s4_d;
        end
    end

    for (genvar j = 1; j <= DIV_N; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (stg_en[S4+j]) begin
                r_lx[S4+j] <= div_step(r_lx[S4+j-1], r_dv[S4+j-1]);
                r_ly[S4+j] <= div_step(r_ly[S4+j-1], r_dv[S4+j-1]);
                r_dv[S4+j] <= r_dv[S4+j-1];
            end
        end
    end

    // ---------------- E1: signed, saturated velocity ----------------
    t_word r_ux, r_uy;

    always_ff @(posedge i_clk) begin
        if (stg_en[E1]) begin
            r_ux <= quot_sat(r_lx[S4+DIV_N]);
            r_uy <= quot_sat(r_ly[S4+DIV_N]);
        end
    end

    // ---------------- E2: squares of u, c.u per direction, rho*w ----------------
    logic signed [63:0]      r_e2_pxx, r_e2_pyy;
    t_word                   r_e2_cu  [NDIR];
    logic signed [PRW_W-1:0] r_e2_prw [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[E2]) begin
            r_e2_pxx    <= r_ux * r_ux;
            r_e2_pyy    <= r_uy * r_uy;
            r_e2_prw[WCLS_REST] <= r_side[E1].rho * W_REST;
            r_e2_prw[WCLS_AXIS] <= r_side[E1].rho * W_AXIS;
            r_e2_prw[WCLS_DIAG] <= r_side[E1].rho * W_DIAG;
            for (int k = 0; k < NDIR; k++) begin
                r_e2_cu[k] <= cu_of(4'(k), r_ux, r_uy);
            end
        end
    end

    // ---------------- E3: u.u, rho*w rounded, (c.u)^2 products ----------------
    t_word              r_e3_uu;
    t_word              r_e3_rw   [3];
    t_word              r_e3_cu   [NDIR];
    logic signed [63:0] r_e3_cu2p [NDIR];

    always_ff @(posedge i_clk) begin
        if (stg_en[E3]) begin
            r_e3_uu <= sat32(qm_round(r_e2_pxx, F) + qm_round(r_e2_pyy, F));
            for (int i = 0; i < 3; i++) begin
                r_e3_rw[i] <= sat32(qm_round(64'(r_e2_prw[i]), F));
            end
            for (int k = 0; k < NDIR; k++) begin
                r_e3_cu2p[k] <= r_e2_cu[k] * r_e2_cu[k];
                r_e3_cu[k]   <= r_e2_cu[k];
            end
        end
    end

    // ---------------- E4: round (c.u)^2 ----------------
    logic [SQ_W-1:0] r_e4_cu2 [NDIR];
    t_word           r_e4_cu  [NDIR];
    t_word           r_e4_uu;
    t_word           r_e4_rw  [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[E4]) begin
            r_e4_uu <= r_e3_uu;
            r_e4_rw <= r_e3_rw;
            for (int k = 0; k < NDIR; k++) begin
                r_e4_cu2[k] <= SQ_W'(qm_round(r_e3_cu2p[k], F));
                r_e4_cu[k]  <= r_e3_cu[k];
            end
        end
    end

    // ---------------- E5: 2 + 6cu + 9cu^2 - 3uu ----------------
    logic signed [PS_W-1:0] n_e5_t [NDIR];
    logic signed [PS_W-1:0] r_e5_t [NDIR];
    t_word                  r_e5_rw [3];

    always_comb begin
        logic signed [PS_W-1:0] c2;
        logic signed [PS_W-1:0] c1;
        logic signed [PS_W-1:0] u1;
        logic signed [PS_W-1:0] two;
        u1       = PS_W'(r_e4_uu);
        two      = '0;
        two[F+1] = 1'b1;
        for (int k = 0; k < NDIR; k++) begin
            c2 = $signed({6'b0, r_e4_cu2[k]});
            c1 = PS_W'(r_e4_cu[k]);
            n_e5_t[k] = two + (c1 <<< 2) + (c1 <<< 1) + (c2 <<< 3) + c2
                        - (u1 <<< 1) - u1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[E5]) begin
            r_e5_t  <= n_e5_t;
            r_e5_rw <= r_e4_rw;
        end
    end

    // ---------------- E6: halve toward zero, saturate ----------------
    t_word r_e6_poly [NDIR];
    t_word r_e6_rw   [3];

    always_ff @(posedge i_clk) begin
        logic signed [PS_W-1:0] th;
        logic signed [PS_W-1:0] h;
        if (stg_en[E6]) begin
            r_e6_rw <= r_e5_rw;
            for (int k = 0; k < NDIR; k++) begin
                th = r_e5_t[k] + {{(PS_W-1){1'b0}}, r_e5_t[k][PS_W-1]};
                h  = th >>> 1;
                r_e6_poly[k] <= sat32(64'(h));
            end
        end
    end

    // ---------------- E7: rho*w*poly ----------------
    logic signed [63:0] r_e7_feqp [NDIR];

    always_ff @(posedge i_clk) begin
        if (stg_en[E7]) begin
            for (int k = 0; k < NDIR; k++) begin
                r_e7_feqp[k] <= r_e6_rw[wcls_of(4'(k))] * r_e6_poly[k];
            end
        end
    end

    // ---------------- E8: equilibrium ----------------
    t_word r_e8_feq [NDIR];

    always_ff @(posedge i_clk) begin
        if (stg_en[E8]) begin
            for (int k = 0; k < NDIR; k++) begin
                r_e8_feq[k] <= sat32(qm_round(r_e7_feqp[k], F));
            end
        end
    end

    // ---------------- E9: f - feq ----------------
    t_word r_e9_diff [NDIR];

    always_ff @(posedge i_clk) begin
        if (stg_en[E9]) begin
            for (int k = 0; k < NDIR; k++) begin
                r_e9_diff[k] <= sat32(64'($signed(r_side[E8].f[k])) - 64'(r_e8_feq[k]));
            end
        end
    end

    // ---------------- E10: omega * (f - feq) ----------------
    logic signed [DP_W-1:0] r_e10_dp [NDIR];

    always_ff @(posedge i_clk) begin
        if (stg_en[E10]) begin
            for (int k = 0; k < NDIR; k++) begin
                r_e10_dp[k] <= $signed({1'b0, r_relax}) * r_e9_diff[k];
            end
        end
    end

    // ---------------- E11: relax, bounce-back / pass-through, output register ----------------
    t_word r_res [NDIR];
    t_word n_res [NDIR];
    logic  e11_pass;

    assign e11_pass = ($signed(r_side[E10].rho) <= 0);

    always_comb begin
        for (int k = 0; k < NDIR; k++) begin
            if (r_side[E10].obstacle) begin
                n_res[k] = r_side[E10].f[opp_of(4'(k))];
            end else if (e11_pass) begin
                n_res[k] = r_side[E10].f[k];
            end else begin
                n_res[k] = sat32(64'($signed(r_side[E10].f[k]))
                                 - qm_round(64'(r_e10_dp[k]), RATE_FRAC));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[E11]) begin
            r_res <= n_res;
        end
    end

    assign o_result.out_rest     = r_res[DIR_REST];
    assign o_result.out_n        = r_res[DIR_N];
    assign o_result.out_ne       = r_res[DIR_NE];
    assign o_result.out_e        = r_res[DIR_E];
    assign o_result.out_se       = r_res[DIR_SE];
    assign o_result.out_s        = r_res[DIR_S];
    assign o_result.out_sw       = r_res[DIR_SW];
    assign o_result.out_w        = r_res[DIR_W];
    assign o_result.out_nw       = r_res[DIR_NW];
    assign o_result.cell_density = r_side[LAST].rho;

endmodule

>>> tb/lbm_collision_checker.sv
// Scoreboard for the D2Q9 collision block: predicts each accepted cell and checks results.
`timescale 1ns / 1ps
module lbm_collision_checker
    import lbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_cell_in           i_cell,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_cell_out          i_result,
    input  logic               i_cfg_we,
    input  logic [RELAX_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam longint ONE_Q  = 64'sd1 << FRAC_BITS_DEF;
    localparam longint W_REST = (8 * ONE_Q + 9) / 18;
    localparam longint W_AXIS = (2 * ONE_Q + 9) / 18;
    localparam longint W_DIAG = (2 * ONE_Q + 36) / 72;

    localparam int     VEL_X [NDIR] = '{0, 0, 1, 1, 1, 0, -1, -1, -1};
    localparam int     VEL_Y [NDIR] = '{0, 1, 1, 0, -1, -1, -1, 0, 1};
    localparam longint WEIGHT[NDIR] = '{W_REST, W_AXIS, W_DIAG, W_AXIS, W_DIAG,
                                        W_AXIS, W_DIAG, W_AXIS, W_DIAG};
    localparam int     MIRROR[NDIR] = '{0, 5, 6, 7, 8, 1, 2, 3, 4};

    logic [RELAX_W-1:0] omega;
    t_cell_out          expected_cells[$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_cells.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // product scaled down with round half away from zero
    function automatic longint mul_round(input longint a, input longint b, input int sh);
        longint p;
        longint mag;
        p   = a * b;
        mag = (p < 0) ? -p : p;
        mag = (mag + (64'sd1 << (sh - 1))) >>> sh;
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic t_cell_out collide(input t_cell_in c, input logic [RELAX_W-1:0] w_rate);
        longint f[NDIR];
        longint res[NDIR];
        longint sum, mx, my, rho, ux, uy, uu, cu, poly, rw, feq, diff;
        t_cell_out r;
        f = '{longint'(c.dist_rest), longint'(c.dist_n), longint'(c.dist_ne),
              longint'(c.dist_e), longint'(c.dist_se), longint'(c.dist_s),
              longint'(c.dist_sw), longint'(c.dist_w), longint'(c.dist_nw)};
        sum = 0;
        mx  = 0;
        my  = 0;
        for (int k = 0; k < NDIR; k++) begin
            sum += f[k];
            mx  += VEL_X[k] * f[k];
            my  += VEL_Y[k] * f[k];
        end
        rho = clamp32(sum);
        if (c.obstacle) begin
            // bounce-back
            for (int k = 0; k < NDIR; k++) res[k] = f[MIRROR[k]];
        end else if (rho <= 0) begin
            res = f;
        end else begin
            ux = clamp32((mx * ONE_Q) / rho);
            uy = clamp32((my * ONE_Q) / rho);
            uu = clamp32(mul_round(ux, ux, FRAC_BITS_DEF) + mul_round(uy, uy, FRAC_BITS_DEF));
            for (int k = 0; k < NDIR; k++) begin
                cu   = clamp32(VEL_X[k] * ux + VEL_Y[k] * uy);
                poly = clamp32((2 * ONE_Q + 6 * cu + 9 * mul_round(cu, cu, FRAC_BITS_DEF)
                                - 3 * uu) / 2);
                rw   = clamp32(mul_round(rho, WEIGHT[k], FRAC_BITS_DEF));
                feq  = clamp32(mul_round(rw, poly, FRAC_BITS_DEF));
                diff = clamp32(f[k] - feq);
                res[k] = clamp32(f[k] - mul_round(longint'(w_rate), diff, RATE_FRAC));
            end
        end
        r.out_rest     = res[0][31:0];
        r.out_n        = res[1][31:0];
        r.out_ne       = res[2][31:0];
        r.out_e        = res[3][31:0];
        r.out_se       = res[4][31:0];
        r.out_s        = res[5][31:0];
        r.out_sw       = res[6][31:0];
        r.out_w        = res[7][31:0];
        r.out_nw       = res[8][31:0];
        r.cell_density = rho[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        t_cell_out        want;
        logic [9:0][31:0] got_w;
        logic [9:0][31:0] want_w;
        string            names[10];
        names = '{"cell_density", "out_nw", "out_w", "out_sw", "out_s",
                  "out_se", "out_e", "out_ne", "out_n", "out_rest"};
        if (!i_rst_n) begin
            omega <= RELAX_RESET;
        end else begin
            if (i_cfg_we) omega <= i_cfg_data;
            if (i_in_valid && i_in_ready) expected_cells.push_back(collide(i_cell, omega));
            if (i_out_valid && i_out_ready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch("unexpected result", i_result.cell_density, '0);
                end else begin
                    want   = expected_cells.pop_front();
                    got_w  = i_result;
                    want_w = want;
                    for (int k = 0; k < 10; k++)
                        if (got_w[k] !== want_w[k]) report_mismatch(names[k], got_w[k], want_w[k]);
                end
            end
        end
    end

endmodule

>>> tb/tb_lbm_d2q9_cell_collision.sv
// Testbench top for lbm_d2q9_cell_collision: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb_lbm_d2q9_cell_collision;
    import lbm_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int RAND_CELLS   = 680;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_cell_in           i_cell;
    logic               o_out_valid;
    logic               i_out_ready;
    t_cell_out          o_result;
    logic               i_cfg_we;
    logic [RELAX_W-1:0] i_cfg_data;

    int   fail_count;
    int   pending;
    bit   idle_on;
    int   cells_sent;
    int   obstacle_sent;
    int   rate_settings;

    lbm_d2q9_cell_collision u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cell      (i_cell),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    lbm_collision_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cell       (i_cell),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog for a hung pipe
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side back-pressure: random stall bursts while idle_on is set
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // one cell transaction; valid stays high across back-to-back items
    task automatic send_cell(input t_cell_in c);
        i_in_valid <= 1'b1;
        i_cell     <= c;
        do @(posedge i_clk); while (!o_in_ready);
        cells_sent++;
        if (c.obstacle) obstacle_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            i_cell     <= t_cell_in'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom, $urandom});
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // wait for the pipe to empty, then change omega
    task automatic set_rate(input logic [RELAX_W-1:0] rate);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= rate;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        rate_settings++;
    endtask

    function automatic t_cell_in make_cell(input logic obs, input t_word d0, input t_word d1,
                                           input t_word d2, input t_word d3, input t_word d4,
                                           input t_word d5, input t_word d6, input t_word d7,
                                           input t_word d8);
        return '{obs, d0, d1, d2, d3, d4, d5, d6, d7, d8};
    endfunction

    // near-equilibrium fluid cell: weights times a density between 0.25 and 4, plus noise
    function automatic t_cell_in physical_cell();
        t_word  base;
        t_word  d[NDIR];
        int     noise;
        base  = t_word'($urandom_range(16384, 262144));
        noise = $urandom_range(0, 3) == 0 ? 65535 : 4095;
        for (int k = 0; k < NDIR; k++) begin
            d[k] = (k == 0) ? (base * 4) / 9 : ((k % 2) ? base / 9 : base / 36);
            d[k] = d[k] + $signed($urandom_range(0, 2 * noise)) - noise;
        end
        return make_cell(1'b0, d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7], d[8]);
    endfunction

    function automatic t_cell_in random_cell();
        t_cell_in c;
        int       pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            c = physical_cell();
        end else if (pick < 8) begin
            c = t_cell_in'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            // small random words: moderate densities of either sign, fast flows
            c = make_cell(1'b0, $signed($urandom_range(0, 1 << 20)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 18));
        end
        c.obstacle = ($urandom_range(0, 4) == 0);
        return c;
    endfunction

    initial begin
        logic [RELAX_W-1:0] rates[5];
        t_word              wmax;
        t_word              wmin;
        wmax          = 32'sh7FFF_FFFF;
        wmin          = 32'sh8000_0000;
        rates         = '{18'd0, 18'd131072, 18'h3FFFF, 18'd65536, 18'd109227};
        idle_on       = 1'b1;
        cells_sent    = 0;
        obstacle_sent = 0;
        rate_settings = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cell        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cells at the reset omega
        send_cell('0);
        send_cell(make_cell(1'b0, wmax, wmax, wmax, wmax, wmax, wmax, wmax, wmax, wmax));
        send_cell(make_cell(1'b0, wmin, wmin, wmin, wmin, wmin, wmin, wmin, wmin, wmin));
        send_cell(make_cell(1'b1, 0, 1, 2, 3, 4, 5, 6, 7, 8));
        send_cell(make_cell(1'b1, wmax, wmin, wmax, wmin, wmax, wmin, wmax, wmin, wmax));
        // resting fluid of unit density
        send_cell(make_cell(1'b0, 29127, 7282, 1821, 7282, 1821, 7282, 1821, 7282, 1821));
        // non-positive density passes through
        send_cell(make_cell(1'b0, -65536, 100, 200, 300, 400, 500, 600, 700, 800));
        send_cell(make_cell(1'b0, -5, 1, 1, 1, 1, 0, 0, 0, 1));
        // extreme velocity: tiny density, huge momentum
        send_cell(make_cell(1'b0, 0, 0, 0, wmax, 0, 0, 0, -32'sd2147483000, 0));
        send_cell(make_cell(1'b0, 0, wmax, 0, 0, 0, -32'sd2147480000, 0, 0, 0));
        send_cell(make_cell(1'b0, 1, 0, wmax, 0, 0, 0, wmin, 0, 0));
        send_cell(make_cell(1'b0, 0, 0, 0, 0, wmax, 0, 0, 0, -32'sd2147483000));
        send_cell(make_cell(1'b0, 65536, 0, 0, 0, 0, 0, 0, 0, 0));

        // random cells across several omega settings, extremes included
        for (int p = 0; p < 5; p++) begin
            set_rate(rates[p]);
            for (int n = 0; n < RAND_CELLS / 6; n++) send_cell(random_cell());
        end
        set_rate(RELAX_W'($urandom_range(1, 131071)));
        // final stretch runs without any idling
        idle_on = 1'b0;
        for (int n = 0; n < RAND_CELLS / 6; n++) send_cell(random_cell());
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d cells (%0d obstacle) over %0d omega writes plus reset value.",
                 cells_sent, obstacle_sent, rate_settings);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
